### hw/rtl/mtcw_pkg.sv
`default_nettype none
package mtcw_pkg;

  localparam int unsigned MAX_SLOTS  = 4;
  localparam int unsigned SLOT_COUNT = 4;
  localparam int unsigned SELF_SLOT  = 0;

  localparam int unsigned SLOT_IDX_W = $clog2(MAX_SLOTS);
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [TIME_W-1:0] LIMIT_RESET = TIME_W'(1000);

  typedef enum logic [1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_UNREGISTER = 2'd1,
    REQ_CHECKIN    = 2'd2,
    REQ_SWEEP      = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic in_is_sweep;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### hw/rtl/mtcw_ctrl.sv
`default_nettype none
module mtcw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mtcw_pkg::sts_t sts_i,
  output mtcw_pkg::cmd_t     cmd_o
);

  mtcw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtcw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mtcw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_is_sweep ? mtcw_pkg::ST_SWEEP : mtcw_pkg::ST_COMMIT;
        end
      end
      mtcw_pkg::ST_SWEEP: begin
        if (sts_i.sweep_last) begin
          state_d = mtcw_pkg::ST_COMMIT;
        end
      end
      mtcw_pkg::ST_COMMIT: begin
        if (sts_i.out_free) begin
          state_d = mtcw_pkg::ST_IDLE;
        end
      end
      default: state_d = mtcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      mtcw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      mtcw_pkg::ST_SWEEP: begin
        cmd_o.step = 1'b1;
      end
      mtcw_pkg::ST_COMMIT: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/mtcw_dp.sv
`default_nettype none
module mtcw_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire mtcw_pkg::cmd_t                      cmd_i,
  output mtcw_pkg::sts_t                           sts_o,
  input  wire logic [1:0]                          req_type_i,
  input  wire logic [mtcw_pkg::SLOT_W-1:0]         slot_i,
  input  wire logic [mtcw_pkg::TIME_W-1:0]         now_i,
  input  wire logic                                cfg_valid_i,
  input  wire logic [mtcw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [mtcw_pkg::TIME_W-1:0]         cfg_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     status_o,
  output logic                                     reset_request_o,
  output logic                                     pet_o
);

  localparam int unsigned N  = mtcw_pkg::MAX_SLOTS;
  localparam int unsigned IW = mtcw_pkg::SLOT_IDX_W;
  localparam int unsigned TW = mtcw_pkg::TIME_W;
  localparam logic [IW-1:0] SELF_IDX = IW'(mtcw_pkg::SELF_SLOT);
  localparam logic [IW-1:0] LAST_IDX = IW'(mtcw_pkg::SLOT_COUNT - 1);
  localparam logic SELF_OK = (mtcw_pkg::SELF_SLOT < mtcw_pkg::SLOT_COUNT);
  localparam logic [N-1:0] REG_RESET = SELF_OK ? (N'(1) << mtcw_pkg::SELF_SLOT) : '0;

  mtcw_pkg::req_type_e        req_type_q;
  logic [mtcw_pkg::SLOT_W-1:0] slot_q;
  logic [TW-1:0]              now_q;
  logic                       fail_q, fail_d;
  logic [IW-1:0]              idx_q, idx_d;

  logic [TW-1:0] limit_q [N];
  logic [TW-1:0] last_q  [N];
  logic [TW-1:0] last_d  [N];
  logic [N-1:0]  reg_q, reg_d;

  logic          out_valid_q;
  logic          status_q, status_d;
  logic          rst_req_q, rst_req_d;
  logic          pet_q, pet_d;

  logic          slot_ok;
  logic [IW-1:0] sidx;
  logic [TW-1:0] elapsed;

  assign sts_o.in_is_sweep = (mtcw_pkg::req_type_e'(req_type_i) == mtcw_pkg::REQ_SWEEP);
  assign sts_o.sweep_last  = (idx_q == LAST_IDX);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign slot_ok = (slot_q < mtcw_pkg::SLOT_W'(mtcw_pkg::SLOT_COUNT));
  assign sidx    = slot_q[IW-1:0];

  // One shared subtract-and-compare checks one slot per sweep cycle.
  assign elapsed = now_q - last_q[idx_q];

  always_comb begin
    fail_d = fail_q;
    idx_d  = idx_q;
    if (cmd_i.load) begin
      fail_d = 1'b0;
      idx_d  = '0;
    end else if (cmd_i.step) begin
      if (reg_q[idx_q] && (elapsed > limit_q[idx_q])) begin
        fail_d = 1'b1;
      end
      idx_d = idx_q + IW'(1);
    end
  end

  always_comb begin
    status_d  = 1'b0;
    rst_req_d = 1'b0;
    pet_d     = 1'b0;
    reg_d     = reg_q;
    last_d    = last_q;
    if (req_type_q == mtcw_pkg::REQ_SWEEP) begin
      if (fail_q) begin
        rst_req_d = 1'b1;
      end else begin
        pet_d = 1'b1;
        if (SELF_OK && reg_q[SELF_IDX]) begin
          last_d[SELF_IDX] = now_q;
        end
      end
    end else if (!slot_ok) begin
      status_d = 1'b1;
    end else begin
      case (req_type_q)
        mtcw_pkg::REQ_REGISTER: begin
          if (reg_q[sidx]) begin
            rst_req_d = 1'b1;
          end else begin
            reg_d[sidx]  = 1'b1;
            last_d[sidx] = now_q;
          end
        end
        mtcw_pkg::REQ_UNREGISTER: begin
          if (!reg_q[sidx]) begin
            rst_req_d = 1'b1;
          end else begin
            reg_d[sidx]  = 1'b0;
            last_d[sidx] = '0;
          end
        end
        default: begin
          if (reg_q[sidx]) begin
            last_d[sidx] = now_q;
          end else begin
            status_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= mtcw_pkg::req_type_e'(req_type_i);
      slot_q     <= slot_i;
      now_q      <= now_i;
    end
    if (cmd_i.commit) begin
      status_q  <= status_d;
      rst_req_q <= rst_req_d;
      pet_q     <= pet_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      reg_q       <= REG_RESET;
      for (int i = 0; i < N; i++) begin
        limit_q[i] <= mtcw_pkg::LIMIT_RESET;
        last_q[i]  <= '0;
      end
    end else begin
      fail_q <= fail_d;
      idx_q  <= idx_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        reg_q <= reg_d;
        for (int i = 0; i < N; i++) begin
          last_q[i] <= last_d[i];
        end
      end
      if (cfg_valid_i) begin
        limit_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign reset_request_o = rst_req_q;
  assign pet_o           = pet_q;

endmodule
`default_nettype wire

### hw/rtl/multi_task_checkin_watchdog.sv
// A register, unregister or check-in transaction is latched on acceptance and its result is
// registered in the commit state; a sweep first checks one slot per cycle, in order,
// through the single shared elapsed-time comparator. A held result stalls the next one.
// A new transaction is accepted only in the idle state, once the previous result has committed.
// Reset clears all check-in times, registers only the self slot, sets every limit to 1000.
`default_nettype none
module multi_task_checkin_watchdog (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic [mtcw_pkg::SLOT_W-1:0]    slot_i,
  input  wire logic [mtcw_pkg::TIME_W-1:0]    now_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                status_o,
  output logic                                reset_request_o,
  output logic                                pet_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mtcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mtcw_pkg::TIME_W-1:0]    cfg_data_i
);

  mtcw_pkg::cmd_t cmd;
  mtcw_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  mtcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtcw_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .slot_i          (slot_i),
    .now_i           (now_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .reset_request_o (reset_request_o),
    .pet_o           (pet_o)
  );

endmodule
`default_nettype wire

### test/tb_multi_task_checkin_watchdog.sv
`default_nettype none
module tb_multi_task_checkin_watchdog;
  import mtcw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_SLOT0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_SLOT1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_SLOT2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_SLOT3 = CFG_IDX_W'(3);

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned STALL_AFTER  = 60;
  localparam int unsigned SETTLE       = 8;

  typedef struct packed {
    req_type_e         kind;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;
  } wd_req_t;

  typedef struct packed {
    logic status;
    logic reset_request;
    logic pet;
  } wd_resp_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic [1:0]           req_type_i  = '0;
  logic [SLOT_W-1:0]    slot_i      = '0;
  logic [TIME_W-1:0]    now_i       = '0;
  logic                 out_ready_i = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [TIME_W-1:0]    cfg_data_i  = '0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 status_o;
  logic                 reset_request_o;
  logic                 pet_o;
  logic                 cfg_ready_o;

  multi_task_checkin_watchdog dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .slot_i          (slot_i),
    .now_i           (now_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .reset_request_o (reset_request_o),
    .pet_o           (pet_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Shadow of the block: per-slot limits, check-in times and registration bits.
  logic [TIME_W-1:0] lim_ticks [MAX_SLOTS];
  logic [TIME_W-1:0] seen_time [MAX_SLOTS];
  logic              armed     [MAX_SLOTS];

  wd_req_t     req_backlog [$];
  wd_resp_t    resp_due    [$];
  wd_req_t     req_on_wire;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned results_seen  = 0;
  int unsigned stall_left    = 0;
  bit          stall_done    = 1'b0;
  int unsigned quiet_cycles  = 0;
  logic [TIME_W-1:0] gen_tick = '0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic wd_resp_t predict_response(input wd_req_t r);
    wd_resp_t                o;
    logic [TIME_W-1:0]       gap;
    logic [SLOT_IDX_W-1:0]   s;
    o = '0;
    s = r.slot[SLOT_IDX_W-1:0];
    if (r.kind == REQ_SWEEP) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        gap = r.now - seen_time[i];
        if (i < SLOT_COUNT && armed[i] && gap > lim_ticks[i]) o.reset_request = 1'b1;
      end
      if (!o.reset_request) begin
        o.pet = 1'b1;
        if (SELF_SLOT < SLOT_COUNT && armed[SELF_SLOT]) seen_time[SELF_SLOT] = r.now;
      end
    end else if (r.slot >= SLOT_COUNT) begin
      o.status = 1'b1;
    end else if (r.kind == REQ_REGISTER) begin
      if (armed[s]) begin
        o.reset_request = 1'b1;
      end else begin
        seen_time[s] = r.now;
        armed[s]     = 1'b1;
      end
    end else if (r.kind == REQ_UNREGISTER) begin
      if (!armed[s]) begin
        o.reset_request = 1'b1;
      end else begin
        seen_time[s] = '0;
        armed[s]     = 1'b0;
      end
    end else begin
      if (armed[s]) seen_time[s] = r.now;
      else o.status = 1'b1;
    end
    return o;
  endfunction

  task automatic check_flag(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_cnt++;
    end
  endtask

  // Driver: once the current request has been taken, offers the next one, with random idle gaps set by send_idle_pct.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        resp_due.push_back(predict_response(req_on_wire));
      end
      if (!in_valid_i || in_ready_o) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_on_wire = req_backlog.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= req_on_wire.kind;
          slot_i     <= req_on_wire.slot;
          now_i      <= req_on_wire.now;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result and drives the receiver's ready, including
  // one long hold-off that lets the block back up into its input.
  always @(posedge clk_i) begin
    wd_resp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (resp_due.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_cnt++;
        end else begin
          want = resp_due.pop_front();
          check_flag("status", want.status, status_o);
          check_flag("reset_request", want.reset_request, reset_request_o);
          check_flag("pet", want.pet, pet_o);
        end
      end
      if (!stall_done && results_seen >= STALL_AFTER) begin
        stall_left = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic push_req(input req_type_e kind, input int unsigned slot,
                          input logic [TIME_W-1:0] now);
    wd_req_t r;
    r.kind = kind;
    r.slot = SLOT_W'(slot);
    r.now  = now;
    req_backlog.push_back(r);
  endtask

  // Mostly plausible software traffic on a running tick count, with some
  // fully random requests mixed in.
  task automatic queue_random(input int unsigned count, input logic [TIME_W-1:0] step);
    wd_req_t     r;
    int unsigned pick;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 12) begin
        r.kind = req_type_e'(2'($urandom_range(3)));
        r.slot = SLOT_W'($urandom_range(7));
        r.now  = $urandom;
      end else begin
        gen_tick = gen_tick + TIME_W'($urandom_range(step));
        pick = $urandom_range(99);
        if (pick < 40) r.kind = REQ_CHECKIN;
        else if (pick < 65) r.kind = REQ_SWEEP;
        else if (pick < 83) r.kind = REQ_REGISTER;
        else r.kind = REQ_UNREGISTER;
        r.slot = ($urandom_range(15) < 14) ? SLOT_W'($urandom_range(SLOT_COUNT - 1))
                                           : SLOT_W'($urandom_range(7, SLOT_COUNT));
        r.now  = gen_tick;
      end
      req_backlog.push_back(r);
    end
  endtask

  // The drain loop tests its exit condition at the falling edge, after every update of the rising edge has settled.
  task automatic drain();
    do @(negedge clk_i);
    while (req_backlog.size() != 0 || in_valid_i || resp_due.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    lim_ticks[idx] = val;
  endtask

  task automatic write_all_limits(input logic [TIME_W-1:0] l0, input logic [TIME_W-1:0] l1,
                                  input logic [TIME_W-1:0] l2, input logic [TIME_W-1:0] l3);
    write_limit(REG_LIMIT_SLOT0, l0);
    write_limit(REG_LIMIT_SLOT1, l1);
    write_limit(REG_LIMIT_SLOT2, l2);
    write_limit(REG_LIMIT_SLOT3, l3);
  endtask

  initial begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      lim_ticks[i] = LIMIT_RESET;
      seen_time[i] = '0;
      armed[i]     = (i == SELF_SLOT);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 13;
    recv_idle_pct = 72;

    // A sweep passes at exactly the limit and fails one tick beyond it.
    push_req(REQ_SWEEP, 0, 32'd0);
    push_req(REQ_SWEEP, 5, 32'd1000);
    push_req(REQ_SWEEP, 7, 32'd2001);
    push_req(REQ_CHECKIN, 0, 32'd2001);
    // Slots at or above the slot count are rejected for every slot request.
    push_req(REQ_REGISTER, 4, 32'd2050);
    push_req(REQ_UNREGISTER, 7, 32'd2050);
    push_req(REQ_CHECKIN, 5, 32'd2050);
    push_req(REQ_REGISTER, 1, 32'd2100);
    push_req(REQ_REGISTER, 1, 32'd2200);
    push_req(REQ_CHECKIN, 2, 32'd2300);
    push_req(REQ_UNREGISTER, 3, 32'd2300);
    push_req(REQ_REGISTER, 3, 32'hFFFF_FF00);
    push_req(REQ_SWEEP, 0, 32'h0000_02E7);
    push_req(REQ_UNREGISTER, 0, 32'h0000_0010);
    push_req(REQ_UNREGISTER, 1, 32'h0000_0020);
    // Elapsed time is taken modulo 2^32 across the wrap of the tick count.
    push_req(REQ_SWEEP, 3, 32'h0000_02E7);
    push_req(REQ_SWEEP, 2, 32'h0000_02E8);
    push_req(REQ_SWEEP, 2, 32'h0000_02E9);
    push_req(REQ_CHECKIN, 3, 32'hFFFF_FFFF);
    push_req(REQ_REGISTER, 0, 32'hFFFF_FFFF);
    push_req(REQ_REGISTER, 2, 32'hFFFF_FFFF);
    push_req(REQ_SWEEP, 6, 32'hFFFF_FFFF);
    push_req(REQ_UNREGISTER, 2, 32'h0000_0000);
    push_req(REQ_CHECKIN, 6, 32'h5555_AAAA);
    drain();

    gen_tick = 32'hFFFF_F800;
    queue_random(380, 32'd150);
    drain();

    write_all_limits('0, '0, '0, '0);
    queue_random(200, 32'd2);
    drain();

    send_idle_pct = 72;
    recv_idle_pct = 13;
    write_all_limits('1, '1, '1, '1);
    queue_random(250, 32'h4000_0000);
    drain();

    write_all_limits(32'd1, 32'd500, 32'd3000, 32'hFFFF_FFFE);
    queue_random(250, 32'd400);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all_limits($urandom_range(5000), $urandom_range(5000),
                     $urandom_range(5000), $urandom_range(5000));
    queue_random(300, 32'd300);
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
